// ===== hdl/htfd_pkg.sv =====
`timescale 1ns / 1ps

package htfd_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // 175000 = 2*65535 + 43930, 125000 = 65535 + 59465
   localparam logic [15:0] TEMP_FRAC_MUL = 16'd43930;
   localparam logic [15:0] HUMI_FRAC_MUL = 16'd59465;
   localparam logic signed [18:0] TEMP_OFFSET = 19'sd45000;
   localparam logic [16:0] HUMI_OFFSET = 17'd6000;
   localparam logic [16:0] HUMI_MAX = 17'd100000;
   localparam logic signed [17:0] TEMP_MIN = -18'sd45000;
   localparam logic signed [17:0] TEMP_MAX = 18'sd130000;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic signed [17:0] temperature_milli_c;
      logic [16:0]        humidity_milli_pct;
      logic               temp_crc_ok;
      logic               humi_crc_ok;
   } rsp_type;

   typedef struct packed {
      logic [15:0] temp_raw;
      logic [15:0] humi_raw;
      logic        temp_ok;
      logic        humi_ok;
   } frame_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== hdl/htfd_front.sv =====
`timescale 1ns / 1ps

module htfd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  htfd_pkg::req_type   req_data,
   output logic                frame_push,
   input  logic                frame_full,
   output htfd_pkg::frame_type frame_data
);

   localparam logic [2:0] BYTE_TEMP_MSB = 3'd0;
   localparam logic [2:0] BYTE_TEMP_LSB = 3'd1;
   localparam logic [2:0] BYTE_TEMP_CRC = 3'd2;
   localparam logic [2:0] BYTE_HUMI_MSB = 3'd3;
   localparam logic [2:0] BYTE_HUMI_LSB = 3'd4;
   localparam logic [2:0] BYTE_HUMI_CRC = 3'd5;

   logic [2:0]  index_ff, index_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] temp_raw_ff, temp_raw_in;
   logic [15:0] humi_raw_ff, humi_raw_in;
   logic        temp_ok_ff, temp_ok_in;
   logic        accept;
   logic [2:0]  pos;
   logic [7:0]  crc_seed, crc_next;
   logic [7:0]  b;

   assign full   = frame_full;
   assign accept = push && !frame_full;
   assign b      = req_data.rx_byte;
   assign pos    = (req_data.frame_start || index_ff > BYTE_HUMI_CRC) ? BYTE_TEMP_MSB : index_ff;

   assign crc_seed = (pos == BYTE_TEMP_MSB || pos == BYTE_HUMI_MSB) ? htfd_pkg::CRC_INIT : crc_ff;
   assign crc_next = htfd_pkg::crc8_update(crc_seed, b);

   always_comb begin
      index_in    = index_ff;
      crc_in      = crc_ff;
      temp_raw_in = temp_raw_ff;
      humi_raw_in = humi_raw_ff;
      temp_ok_in  = temp_ok_ff;
      frame_push  = 1'b0;
      if (accept) begin
         index_in = pos + 3'd1;
         unique case (pos)
            BYTE_TEMP_MSB: begin
               crc_in = crc_next;
               temp_raw_in[15:8] = b;
            end
            BYTE_TEMP_LSB: begin
               crc_in = crc_next;
               temp_raw_in[7:0] = b;
            end
            BYTE_TEMP_CRC: begin
               temp_ok_in = (crc_ff == b);
               crc_in = htfd_pkg::CRC_INIT;
            end
            BYTE_HUMI_MSB: begin
               crc_in = crc_next;
               humi_raw_in[15:8] = b;
            end
            BYTE_HUMI_LSB: begin
               crc_in = crc_next;
               humi_raw_in[7:0] = b;
            end
            default: begin
               crc_in     = htfd_pkg::CRC_INIT;
               index_in   = BYTE_TEMP_MSB;
               frame_push = 1'b1;
            end
         endcase
      end
   end

   assign frame_data.temp_raw = temp_raw_ff;
   assign frame_data.humi_raw = humi_raw_ff;
   assign frame_data.temp_ok  = temp_ok_ff;
   assign frame_data.humi_ok  = (crc_ff == b);

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff    <= BYTE_TEMP_MSB;
         crc_ff      <= htfd_pkg::CRC_INIT;
         temp_raw_ff <= '0;
         humi_raw_ff <= '0;
         temp_ok_ff  <= 1'b0;
      end else begin
         index_ff    <= index_in;
         crc_ff      <= crc_in;
         temp_raw_ff <= temp_raw_in;
         humi_raw_ff <= humi_raw_in;
         temp_ok_ff  <= temp_ok_in;
      end
   end

`ifndef SYNTHESIS
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      index_ff <= BYTE_HUMI_CRC)
      else $error("byte position out of range");
   a_push_wraps: assert property (@(posedge clock) disable iff (reset)
      frame_push |=> index_ff == BYTE_TEMP_MSB && crc_ff == htfd_pkg::CRC_INIT)
      else $error("frame end did not restart position and crc");
   a_push_accepted: assert property (@(posedge clock) disable iff (reset)
      frame_push |-> push && !frame_full)
      else $error("frame pushed without accepted byte");
`endif

endmodule

// ===== hdl/htfd_queue.sv =====
`timescale 1ns / 1ps

module htfd_queue #(
   parameter int DEPTH = htfd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_push,
   output logic                wr_full,
   input  htfd_pkg::frame_type wr_data,
   input  logic                rd_pop,
   output logic                rd_empty,
   output htfd_pkg::frame_type rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   htfd_pkg::frame_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign wr_full  = (count_ff == FULL_CNT);
   assign rd_empty = (count_ff == '0);
   assign do_wr    = wr_push && !wr_full;
   assign do_rd    = rd_pop && !rd_empty;
   assign rd_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count overflow");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      do_wr && !do_rd |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a write");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_CNT) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");
`endif

endmodule

// ===== hdl/htfd_back.sv =====
`timescale 1ns / 1ps

module htfd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                frame_empty,
   output logic                frame_pop,
   input  htfd_pkg::frame_type frame_data,
   output logic                empty,
   input  logic                pop,
   output htfd_pkg::rsp_type   rsp_data
);

   // stage 1: fractional products
   logic        s1_valid_ff;
   logic [31:0] s1_temp_prod_ff, s1_humi_prod_ff;
   logic [15:0] s1_temp_raw_ff, s1_humi_raw_ff;
   logic        s1_temp_ok_ff, s1_humi_ok_ff;
   // stage 2: scaled magnitudes
   logic        s2_valid_ff;
   logic [17:0] s2_temp_ff, s2_temp_in;
   logic [16:0] s2_humi_ff, s2_humi_in;
   logic        s2_temp_ok_ff, s2_humi_ok_ff;
   // stage 3: output register
   logic              s3_valid_ff;
   htfd_pkg::rsp_type s3_rsp_ff, s3_rsp_in;

   logic        s1_ready, s2_ready, s3_ready;
   logic [32:0] temp_sum, humi_sum;
   logic [16:0] temp_quot, humi_quot;
   logic signed [18:0] temp_wide;
   logic [16:0] humi_diff;

   assign s3_ready  = !s3_valid_ff || pop;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign frame_pop = !frame_empty && s1_ready;

   // floor(y / 65535) = (y + (y >> 16) + 1) >> 16 for y well below 2^32
   assign temp_sum  = {1'b0, s1_temp_prod_ff} + 33'(s1_temp_prod_ff[31:16]) + 33'd1;
   assign humi_sum  = {1'b0, s1_humi_prod_ff} + 33'(s1_humi_prod_ff[31:16]) + 33'd1;
   assign temp_quot = temp_sum[32:16];
   assign humi_quot = humi_sum[32:16];
   assign s2_temp_in = {1'b0, s1_temp_raw_ff, 1'b0} + {1'b0, temp_quot};
   assign s2_humi_in = {1'b0, s1_humi_raw_ff} + humi_quot;

   assign temp_wide = $signed({1'b0, s2_temp_ff}) - htfd_pkg::TEMP_OFFSET;
   assign humi_diff = s2_humi_ff - htfd_pkg::HUMI_OFFSET;

   always_comb begin
      s3_rsp_in.temperature_milli_c = temp_wide[17:0];
      if (s2_humi_ff < htfd_pkg::HUMI_OFFSET) begin
         s3_rsp_in.humidity_milli_pct = '0;
      end else if (humi_diff > htfd_pkg::HUMI_MAX) begin
         s3_rsp_in.humidity_milli_pct = htfd_pkg::HUMI_MAX;
      end else begin
         s3_rsp_in.humidity_milli_pct = humi_diff;
      end
      s3_rsp_in.temp_crc_ok = s2_temp_ok_ff;
      s3_rsp_in.humi_crc_ok = s2_humi_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= frame_pop;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (frame_pop) begin
         s1_temp_prod_ff <= frame_data.temp_raw * htfd_pkg::TEMP_FRAC_MUL;
         s1_humi_prod_ff <= frame_data.humi_raw * htfd_pkg::HUMI_FRAC_MUL;
         s1_temp_raw_ff  <= frame_data.temp_raw;
         s1_humi_raw_ff  <= frame_data.humi_raw;
         s1_temp_ok_ff   <= frame_data.temp_ok;
         s1_humi_ok_ff   <= frame_data.humi_ok;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_temp_ff    <= s2_temp_in;
         s2_humi_ff    <= s2_humi_in;
         s2_temp_ok_ff <= s1_temp_ok_ff;
         s2_humi_ok_ff <= s1_humi_ok_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_rsp_ff <= s3_rsp_in;
      end
   end

   assign empty    = !s3_valid_ff;
   assign rsp_data = s3_rsp_ff;

`ifndef SYNTHESIS
   a_humi_clamped: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> s3_rsp_ff.humidity_milli_pct <= htfd_pkg::HUMI_MAX)
      else $error("humidity out of range");
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> s3_rsp_ff.temperature_milli_c >= htfd_pkg::TEMP_MIN
                   && s3_rsp_ff.temperature_milli_c <= htfd_pkg::TEMP_MAX)
      else $error("temperature out of range");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s3_ready |=> s2_valid_ff)
      else $error("stage two result dropped under stall");
`endif

endmodule

// ===== hdl/humidity_temp_frame_decoder.sv =====
`timescale 1ns / 1ps

// Channel   Ports                     Transfer
// input     push, full, req_data      push && !full
// result    empty, pop, rsp_data      pop && !empty
//
// One byte per cycle is accepted while full is low; the sixth byte of a frame queues one frame record.
// The queue write shares the edge that takes a frame's sixth byte; from the queue the result
// passes the registered scaling stages (multiply, divide by 65535, offset/clamp) before it
// shows on rsp_data.
// Reset is synchronous and clears position, CRC, queue and pipeline valids.
// full follows the frame queue only; a stalled result backs up the pipeline, then the
// queue, before input stalls.

module humidity_temp_frame_decoder #(
   parameter int QUEUE_DEPTH = htfd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  htfd_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output htfd_pkg::rsp_type rsp_data
);

   logic                wr_push, wr_full, rd_pop, rd_empty;
   htfd_pkg::frame_type wr_data, rd_data;

   htfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .frame_push (wr_push),
      .frame_full (wr_full),
      .frame_data (wr_data)
   );

   htfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (wr_push),
      .wr_full  (wr_full),
      .wr_data  (wr_data),
      .rd_pop   (rd_pop),
      .rd_empty (rd_empty),
      .rd_data  (rd_data)
   );

   htfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_empty (rd_empty),
      .frame_pop   (rd_pop),
      .frame_data  (rd_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data)
   );

endmodule
